### src/i32div_pkg.sv
// ----------------------------------------------------------------------------
// i32div_pkg: shared types and constants of the 32-bit integer divider
// word widths, pipeline depth, operation codes and the stage record
// ----------------------------------------------------------------------------
package i32div_pkg;

   // operand and result width
   localparam int DATA_W = 32;

   // one restoring step per stage, one stage per quotient bit
   localparam int STAGES = DATA_W;

   // operation select carried on tuser
   typedef enum logic {
      OP_UNSIGNED = 1'b0,
      OP_SIGNED   = 1'b1
   } op_type;

   // payload of one division stage
   typedef struct packed {
      logic [DATA_W-1:0] part;  // partial remainder
      logic [DATA_W-1:0] numq;  // dividend bits still to shift in, quotient bits behind
      logic [DATA_W-1:0] den;   // divisor magnitude
      logic              neg_q; // negate quotient at the end
      logic              neg_r; // negate remainder at the end
   } stage_type;

   // result word
   typedef struct packed {
      logic [DATA_W-1:0] remainder;
      logic [DATA_W-1:0] quotient;
   } result_type;

endpackage

### src/int32_divider_signed_unsigned.sv
// ----------------------------------------------------------------------------
// int32_divider_signed_unsigned: pipelined 32-bit signed/unsigned divider
// restoring shift-subtract division, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
// Accepts one division word per clock while req_tready is high and returns
// one result word per division, in order. On the way, the accepting edge
// loads the operand magnitudes into the entry register, 32 stages each
// resolve one quotient bit with a 33-bit subtract, and the signs are applied
// as the result enters the output register. A two-entry output buffer lets
// the pipe keep taking words while a finished result waits;
// req_tready drops only once both entries are full.
// Division by zero gives an all-ones magnitude quotient and the dividend's
// magnitude as remainder, then the usual sign fixes; the most negative number
// divided by minus one wraps to itself with a zero remainder.
module int32_divider_signed_unsigned (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] dividend, [63:32] divisor
   input  logic        req_tuser,   // [0] operation (0 unsigned, 1 signed)
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [31:0] quotient, [63:32] remainder
);

   localparam int W = i32div_pkg::DATA_W;
   localparam int N = i32div_pkg::STAGES;

   // pipeline registers
   i32div_pkg::stage_type stage_ff [0:N];
   i32div_pkg::stage_type stage_in [0:N];
   logic [N:0]            stage_valid_ff;
   logic [N:0]            stage_valid_in;

   // output register and skid entry
   i32div_pkg::result_type out_ff, out_in;
   i32div_pkg::result_type skid_ff, skid_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;

   logic                   advance;
   logic                   new_valid;
   i32div_pkg::result_type new_result;

   logic [W-1:0]           req_dividend;
   logic [W-1:0]           req_divisor;
   i32div_pkg::op_type     req_op;
   logic                   num_neg;
   logic                   den_neg;

   // pipe moves whenever the skid entry is free
   assign advance    = !skid_valid_ff;
   assign req_tready = advance;

   assign req_dividend = req_tdata[W-1:0];
   assign req_divisor  = req_tdata[2*W-1:W];
   assign req_op       = i32div_pkg::op_type'(req_tuser);

   // entry stage: magnitudes and sign flags, then restoring steps
   always_comb begin
      logic [W:0] shifted;
      logic [W:0] diff;
      num_neg = (req_op == i32div_pkg::OP_SIGNED) && req_dividend[W-1];
      den_neg = (req_op == i32div_pkg::OP_SIGNED) && req_divisor[W-1];
      stage_in[0].part  = '0;
      stage_in[0].numq  = num_neg ? (W'(0) - req_dividend) : req_dividend;
      stage_in[0].den   = den_neg ? (W'(0) - req_divisor) : req_divisor;
      stage_in[0].neg_q = num_neg ^ den_neg;
      stage_in[0].neg_r = num_neg;
      stage_valid_in[0] = req_tvalid;
      // one quotient bit per stage
      shifted = '0;
      diff    = '0;
      for (int i = 0; i < N; i++) begin
         shifted = {stage_ff[i].part, stage_ff[i].numq[W-1]};
         diff    = shifted - {1'b0, stage_ff[i].den};
         stage_in[i+1] = stage_ff[i];
         if (!diff[W]) begin
            stage_in[i+1].part = diff[W-1:0];
            stage_in[i+1].numq = {stage_ff[i].numq[W-2:0], 1'b1};
         end else begin
            stage_in[i+1].part = shifted[W-1:0];
            stage_in[i+1].numq = {stage_ff[i].numq[W-2:0], 1'b0};
         end
         stage_valid_in[i+1] = stage_valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else if (advance) begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i <= N; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   // sign fix on the last stage
   always_comb begin
      new_valid = advance && stage_valid_ff[N];
      new_result.quotient  = stage_ff[N].neg_q ? (W'(0) - stage_ff[N].numq)
                                               : stage_ff[N].numq;
      new_result.remainder = stage_ff[N].neg_r ? (W'(0) - stage_ff[N].part)
                                               : stage_ff[N].part;
   end

   // output register with skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (new_valid) begin
            out_in       = new_result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (new_valid) begin
         skid_in       = new_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.remainder, out_ff.quotient};

   // skid entry is only ever behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a word while output register is empty");

   // skid fills only when the output word was held back
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_tready))
      else $error("skid entry filled while output register was free");

   // a stalled pipe keeps its occupancy
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stage_valid_ff))
      else $error("pipeline occupancy changed during stall");

   // final partial remainder stays below a nonzero divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff[N] && (stage_ff[N].den != '0)) |->
         (stage_ff[N].part < stage_ff[N].den))
      else $error("remainder magnitude not below divisor magnitude");

endmodule
